// File: rtl/core/windowed_masked_histogram_top_defines.svh
// Assertion macros shared by the histogram block.
`ifndef WINDOWED_MASKED_HISTOGRAM_TOP_DEFINES_SVH
`define WINDOWED_MASKED_HISTOGRAM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define WMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define WMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/wmh_pkg.sv
// Types, codes and constants of the windowed masked histogram.
package wmh_pkg;
    localparam int NUM_BINS_DEF    = 65536;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CLAMP_MAX_DEF   = 4095;
    localparam int BIN_W           = 16;
    localparam int TOTAL_W         = 32;
    localparam int PADDR_W         = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [12:0] BOX_END_RESET = 13'd4096;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_U16 = 2'd1,
        FMT_U12 = 2'd2,
        FMT_ALT = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        MODE_ACC   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_COUNT = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_FORMAT    = 3'd0,
        REG_USE_MASK  = 3'd1,
        REG_COL_FIRST = 3'd2,
        REG_ROW_FIRST = 3'd3,
        REG_COL_END   = 3'd4,
        REG_ROW_END   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        B_SWEEP = 2'd0,
        B_IDLE  = 2'd1,
        B_WAIT  = 2'd2
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        fmt_t        format;
        logic        use_mask;
        logic [11:0] col_first;
        logic [11:0] row_first;
        logic [12:0] col_end;
        logic [12:0] row_end;
    } cfg_t;

    typedef struct packed {
        logic sweeping;
        logic result_held;
    } back_status_t;
endpackage

// File: rtl/core/wmh_if.sv
// Request and result channel interfaces of the histogram block.
interface wmh_in_if import wmh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [11:0]      row;
    logic [11:0]      col;
    logic [15:0]      pixel;
    logic [7:0]       mask_byte;
    logic [BIN_W-1:0] bin_index;

    modport source (output valid, mode, row, col, pixel, mask_byte, bin_index, input ready);
    modport sink (input valid, mode, row, col, pixel, mask_byte, bin_index, output ready);
endinterface

interface wmh_out_if import wmh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               counted;
    logic [31:0]        bin_count;
    logic [TOTAL_W-1:0] pixel_total;

    modport source (output valid, counted, bin_count, pixel_total, input ready);
    modport sink (input valid, counted, bin_count, pixel_total, output ready);
endinterface

// File: rtl/core/wmh_ram.sv
// Generic single-port-write, registered-read RAM.
module wmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/wmh_front.sv
// Front end: takes requests and classifies them into bin commands.
module wmh_front import wmh_pkg::*; #(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int CLAMP_MAX = CLAMP_MAX_DEF
) (
    wmh_in_if.sink pix_in,
    input  cfg_t   cfg,
    input  logic   q_full,
    output logic   push,
    output cmd_t   cmd
);
    logic             in_box;
    logic             qualifies;
    logic [BIN_W-1:0] bin;
    logic             bin_ok;
    logic             idx_ok;

    always_comb
    begin
        in_box = ({1'b0, pix_in.row} >= {1'b0, cfg.row_first}) &&
                 ({1'b0, pix_in.row} < cfg.row_end) &&
                 ({1'b0, pix_in.col} >= {1'b0, cfg.col_first}) &&
                 ({1'b0, pix_in.col} < cfg.col_end);
        qualifies = cfg.use_mask ? (pix_in.mask_byte != 8'd0) : in_box;

        case (cfg.format)
            FMT_U8:  bin = {{(BIN_W-8){1'b0}}, pix_in.pixel[7:0]};
            FMT_U12: bin = (pix_in.pixel > BIN_W'(CLAMP_MAX)) ? BIN_W'(CLAMP_MAX)
                                                              : pix_in.pixel;
            default: bin = pix_in.pixel;
        endcase

        bin_ok = {1'b0, bin} < (BIN_W+1)'(NUM_BINS);
        idx_ok = {1'b0, pix_in.bin_index} < (BIN_W+1)'(NUM_BINS);

        cmd.addr = bin;
        cmd.op   = OP_NOP;
        case (mode_t'(pix_in.mode))
            MODE_ACC:
            begin
                cmd.op = (qualifies && bin_ok) ? OP_COUNT : OP_NOP;
            end
            MODE_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            MODE_READ:
            begin
                cmd.op   = idx_ok ? OP_READ : OP_NOP;
                cmd.addr = pix_in.bin_index;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    assign pix_in.ready = !q_full;
    assign push         = pix_in.valid && !q_full;
endmodule

// File: rtl/core/wmh_queue.sv
// Short command queue between the front and back ends.
module wmh_queue import wmh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = count_reg == (PW+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
endmodule

// File: rtl/core/wmh_back.sv
// Back end: sequences bin memory read-modify-write, reads and clear sweeps.
module wmh_back import wmh_pkg::*; #(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  cmd_t          cmd,
    output logic          pop,
    wmh_out_if.source     res_out,
    output back_status_t  status
);
    localparam int AW = $clog2(NUM_BINS);

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      sweep_cnt_reg;
    logic               clear_cmd_reg;
    op_t                cur_op_reg;
    logic [AW-1:0]      cur_addr_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_counted_reg;
    logic [31:0]        out_bin_reg;

    logic                   take;
    logic                   sweep_last;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] bin_inc;
    logic                   res_set;
    logic                   res_counted;
    logic [31:0]            res_bin;

    wmh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign take       = !out_valid_reg || res_out.ready;
    assign sweep_last = sweep_cnt_reg == AW'(NUM_BINS - 1);
    assign bin_inc    = (ram_rdata != '1) ? ram_rdata + COUNT_WIDTH'(1) : ram_rdata;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop && (cmd.op == OP_COUNT || cmd.op == OP_READ))
                begin
                    state_next = B_WAIT;
                end
                else if (pop && cmd.op == OP_CLEAR)
                begin
                    state_next = B_SWEEP;
                end
            end
            B_WAIT:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr_reg;
        ram_wdata   = bin_inc;
        total_next  = total_reg;
        res_set     = 1'b0;
        res_counted = 1'b0;
        res_bin     = '0;
        case (state_reg)
            B_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = '0;
                res_set   = sweep_last && clear_cmd_reg;
            end
            B_IDLE:
            begin
                pop = !q_empty && take;
                if (pop && cmd.op == OP_CLEAR)
                begin
                    total_next = '0;
                end
                res_set = pop && cmd.op == OP_NOP;
            end
            B_WAIT:
            begin
                res_set = 1'b1;
                if (cur_op_reg == OP_COUNT)
                begin
                    ram_we      = 1'b1;
                    res_counted = 1'b1;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                end
                else
                begin
                    res_bin = 32'(ram_rdata);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        out_valid_next = res_set || (out_valid_reg && !res_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            sweep_cnt_reg <= '0;
            clear_cmd_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            // The sweep address returns to zero after the last bin, so the
            // next sweep starts at bin zero for any bin count.
            if (state_reg == B_SWEEP)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + AW'(1);
            end
            if (pop)
            begin
                clear_cmd_reg <= cmd.op == OP_CLEAR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_op_reg   <= cmd.op;
            cur_addr_reg <= cmd.addr[AW-1:0];
        end
        if (res_set)
        begin
            out_counted_reg <= res_counted;
            out_bin_reg     <= res_bin;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.counted     = out_counted_reg;
    assign res_out.bin_count   = out_bin_reg;
    assign res_out.pixel_total = total_reg;

    assign status.sweeping    = state_reg == B_SWEEP;
    assign status.result_held = out_valid_reg;
endmodule

// File: rtl/core/windowed_masked_histogram_top.sv
// A counted pixel or a bin read passes the command queue, the registered bin memory read
// and the output register. A count or a read holds the back end in a wait state, so it
// takes no new item until that one is through; items that touch no bin go one per cycle
// while the output is not stalled. Reset: asynchronous; afterwards a sweep zeroes the bin
// memory, during which up to two requests are queued and configuration writes are taken.
`include "windowed_masked_histogram_top_defines.svh"
module windowed_masked_histogram_top import wmh_pkg::*; #(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int CLAMP_MAX   = CLAMP_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    wmh_in_if.sink             pix_in,
    wmh_out_if.source          res_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // Configuration registers, written by the APB port. The register index is the
    // word address; byte lanes are ignored.
    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    // Front to queue, queue to back.
    logic         q_push;
    cmd_t         q_push_cmd;
    logic         q_pop;
    cmd_t         q_head;
    logic         q_full;
    logic         q_empty;
    back_status_t status;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format    <= FMT_U8;
            cfg_reg.use_mask  <= 1'b0;
            cfg_reg.col_first <= '0;
            cfg_reg.row_first <= '0;
            cfg_reg.col_end   <= BOX_END_RESET;
            cfg_reg.row_end   <= BOX_END_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_FORMAT:    cfg_reg.format    <= fmt_t'(pwdata[1:0]);
                REG_USE_MASK:  cfg_reg.use_mask  <= pwdata[0];
                REG_COL_FIRST: cfg_reg.col_first <= pwdata[11:0];
                REG_ROW_FIRST: cfg_reg.row_first <= pwdata[11:0];
                REG_COL_END:   cfg_reg.col_end   <= pwdata[12:0];
                REG_ROW_END:   cfg_reg.row_end   <= pwdata[12:0];
                default:       cfg_reg.use_mask  <= cfg_reg.use_mask;
            endcase
        end
    end

    // Read-back of the register selected by the address; unmapped words read zero.
    always_comb
    begin
        case (reg_idx)
            REG_FORMAT:    prdata = {30'd0, cfg_reg.format};
            REG_USE_MASK:  prdata = {31'd0, cfg_reg.use_mask};
            REG_COL_FIRST: prdata = {20'd0, cfg_reg.col_first};
            REG_ROW_FIRST: prdata = {20'd0, cfg_reg.row_first};
            REG_COL_END:   prdata = {19'd0, cfg_reg.col_end};
            REG_ROW_END:   prdata = {19'd0, cfg_reg.row_end};
            default:       prdata = '0;
        endcase
    end

    // The front end decides, in the cycle a request arrives, whether it touches a bin
    // and which one; everything that needs the bin memory is left to the back end.
    wmh_front #(.NUM_BINS(NUM_BINS), .CLAMP_MAX(CLAMP_MAX)) u_front (
        .pix_in (pix_in),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (q_push_cmd)
    );

    // The queue lets requests arrive while the back end sweeps or waits on the output.
    wmh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // The back end owns the bin memory and the running pixel total.
    wmh_back #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .cmd     (q_head),
        .pop     (q_pop),
        .res_out (res_out),
        .status  (status)
    );

    // A sweep only starts once the output register is free, and it stays free until the end.
    `WMH_ASSERT_IMP(a_sweep_no_result, clk, rst_n, status.sweeping, !status.result_held, "result held during sweep")
    // The total saturates and never wraps, so a counted pixel leaves it nonzero.
    `WMH_ASSERT_IMP(a_counted_total, clk, rst_n, res_out.valid && res_out.counted, res_out.pixel_total != 32'd0, "counted pixel with zero total")
    // Only reads return a bin value, and reads never count.
    `WMH_ASSERT_IMP(a_read_not_counted, clk, rst_n, res_out.valid && res_out.bin_count != 32'd0, !res_out.counted, "bin value on a counted result")
    // With no pop the full queue cannot drain or overflow.
    `WMH_ASSERT_NEXT(a_queue_hold, clk, rst_n, q_full && !q_pop, q_full, "full queue changed without a pop")
endmodule
